@@ rtl/erm5_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm5_pkg: shared types and constants for the echo range median filter
// Holds the field widths, the distance conversion constant and the command
// and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package erm5_pkg;

  // Field widths.
  localparam int ECHO_W   = 16;
  localparam int DIST_W   = 17;
  localparam int SAMPLE_W = DIST_W + 1;

  // Reset value of the timeout register, in microseconds.
  localparam logic [ECHO_W-1:0] TIMEOUT_RESET = 16'd30000;

  // distance = floor(echo * 17 / 10), done as echo * ceil(17 * 2^23 / 10) >> 23.
  // The rounding error stays below one unit for every 16-bit echo.
  localparam int                RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP      = 24'd14260634;
  localparam int                RECIP_SHIFT = 23;
  localparam int                PROD_W      = ECHO_W + RECIP_W;

  // Stored sample word for a timed-out echo: invalid mark set, distance zero.
  localparam logic [SAMPLE_W-1:0] INVALID_SAMPLE = {1'b1, {DIST_W{1'b0}}};

  // Controller state, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CONV   = 4'b0010,
    S_INSERT = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the echo duration of an accepted beat
    logic convert;  // form the stored sample word
    logic insert;   // insert the sample into the sorted group
    logic emit;     // present the median and start a new group
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the sample being inserted completes the group
  } status_t;

endpackage

@@ rtl/erm5_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm5_ctrl: sequencer for the echo range median filter
// Walks each accepted beat through capture, conversion and insertion, and
// raises the result strobe for one cycle when a group completes.
// ----------------------------------------------------------------------------
module erm5_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  erm5_pkg::status_t status,
  output erm5_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import erm5_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.convert = 1'b1;
        state_next  = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_EMIT);

endmodule

@@ rtl/erm5_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm5_datapath: conversion, insertion chain and median tap
// Converts an echo duration to a distance word, keeps the current group in
// ascending order by insertion and presents the middle entry.
// ----------------------------------------------------------------------------
module erm5_datapath #(
  parameter int WINDOW = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  erm5_pkg::cmd_t                cmd,
  output erm5_pkg::status_t             status,
  input  logic [erm5_pkg::ECHO_W-1:0]   echo_us,
  input  logic                          cfg_we,
  input  logic [erm5_pkg::ECHO_W-1:0]   cfg_wdata,
  output logic [erm5_pkg::DIST_W-1:0]   distance_centi_cm,
  output logic                          distance_valid
);
  import erm5_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int MID   = WINDOW / 2;

  logic [ECHO_W-1:0]   timeout_limit;
  logic [ECHO_W-1:0]   echo_q;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] sorted [WINDOW];
  logic [SAMPLE_W-1:0] sorted_next [WINDOW];
  logic [CNT_W-1:0]    count;
  logic [PROD_W-1:0]   prod;
  logic                invalid;
  logic [WINDOW-1:0]   gt;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_wdata;
    end
  end

  // Capture of the accepted echo duration.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      echo_q <= echo_us;
    end
  end

  // Conversion to a stored sample word: one multiply by the scaled factor.
  assign prod    = PROD_W'(echo_q) * PROD_W'(RECIP);
  assign invalid = (echo_q == '0) || (echo_q > timeout_limit);

  always_ff @(posedge clk) begin
    if (cmd.convert) begin
      sample <= invalid ? INVALID_SAMPLE
                        : {1'b0, prod[RECIP_SHIFT +: DIST_W]};
    end
  end

  // Each held entry compares against the new sample at once; the entries
  // above it form a suffix of the held part and move up by one place.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      gt[i] = (CNT_W'(i) < count) && (sorted[i] > sample);
    end
    for (int i = 0; i < WINDOW; i++) begin
      sorted_next[i] = sorted[i];
      if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
        sorted_next[i] = sorted[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || (CNT_W'(i) == count)) begin
        sorted_next[i] = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < WINDOW; i++) begin
        sorted[i] <= sorted_next[i];
      end
    end
  end

  // Group fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.emit) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + 1'b1;
    end
  end

  assign status.last = (count == CNT_W'(WINDOW - 1));

  // Median tap; an invalid median reports zero distance.
  assign distance_valid    = ~sorted[MID][SAMPLE_W-1];
  assign distance_centi_cm = sorted[MID][SAMPLE_W-1] ? '0 : sorted[MID][DIST_W-1:0];

endmodule

@@ rtl/echo_range_median5_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_median5_filter: median range filter for ultrasonic echoes
// Converts echo durations to distances and reports the median of each group.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; the duration is
// captured at that edge. Busy then stays high through the conversion
// multiply and the insertion of the sample into the sorted group. The beat
// that completes a group of WINDOW samples adds an emit state, in which
// done is high for exactly one cycle with the median on distance_centi_cm
// and distance_valid; the receiver cannot stall and must take it then. A
// new group starts straight after. The timeout register, written through
// cfg_we and cfg_wdata, resets to 30000 us; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module echo_range_median5_filter #(
  parameter int WINDOW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [erm5_pkg::ECHO_W-1:0] echo_us,
  input  logic                        cfg_we,
  input  logic [erm5_pkg::ECHO_W-1:0] cfg_wdata,
  output logic                        done,
  output logic [erm5_pkg::DIST_W-1:0] distance_centi_cm,
  output logic                        distance_valid
);
  import erm5_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  erm5_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Conversion and ordering datapath.
  erm5_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .echo_us           (echo_us),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .distance_centi_cm (distance_centi_cm),
    .distance_valid    (distance_valid)
  );

endmodule

@@ test/echo_range_median5_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_median5_filter_test: self-checking bench for the median filter
// A directed table of echo beats comes first: the timeout boundary, empty
// echoes, the largest duration and groups that are mostly invalid. Random
// beats follow under several timeout settings, the extremes among them. Each
// accepted beat runs through a predictor of the grouping and median logic,
// and every done beat is compared with the oldest predicted median.
// ----------------------------------------------------------------------------
module echo_range_median5_filter_test;
  import erm5_pkg::*;

  localparam int WINDOW        = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 180;
  localparam int PHASE_COUNT   = 8;
  localparam int DIRECTED_ROWS = 25;

  // One median result as it appears on the result ports.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              valid;
  } median_t;

  // One directed row: the echo, and a typed-in median where the row closes
  // a group whose result is plain to see.
  typedef struct packed {
    logic [ECHO_W-1:0] echo;
    logic              typed;
    logic [DIST_W-1:0] distance;
    logic              valid;
  } echo_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [ECHO_W-1:0] echo_us = '0;
  logic              cfg_we = 1'b0;
  logic [ECHO_W-1:0] cfg_wdata = '0;
  logic              done;
  logic [DIST_W-1:0] distance_centi_cm;
  logic              distance_valid;

  // Predictor state: the timeout setting and the current group of samples.
  logic [ECHO_W-1:0]   limit_us = TIMEOUT_RESET;
  logic [SAMPLE_W-1:0] group_samples [WINDOW];
  int                  group_fill = 0;

  median_t pending_medians [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // Directed rows, run at the reset timeout of 30000 us.
  echo_row_t directed_rows [DIRECTED_ROWS] = '{
    // Empty echo, largest echo, one past the timeout: the median is invalid.
    '{16'd0,     1'b0, 17'd0,     1'b0},
    '{16'd65535, 1'b0, 17'd0,     1'b0},
    '{16'd30001, 1'b0, 17'd0,     1'b0},
    '{16'd0,     1'b0, 17'd0,     1'b0},
    '{16'd0,     1'b1, 17'd0,     1'b0},
    // Shortest valid echo.
    '{16'd1,     1'b0, 17'd0,     1'b0},
    '{16'd1,     1'b0, 17'd0,     1'b0},
    '{16'd1,     1'b0, 17'd0,     1'b0},
    '{16'd1,     1'b0, 17'd0,     1'b0},
    '{16'd1,     1'b1, 17'd1,     1'b1},
    // Echo exactly at the timeout is still accepted.
    '{16'd30000, 1'b0, 17'd0,     1'b0},
    '{16'd30000, 1'b0, 17'd0,     1'b0},
    '{16'd30000, 1'b0, 17'd0,     1'b0},
    '{16'd30000, 1'b0, 17'd0,     1'b0},
    '{16'd30000, 1'b1, 17'd51000, 1'b1},
    // Two invalid samples rank above the valid ones; the median is valid.
    '{16'd30000, 1'b0, 17'd0,     1'b0},
    '{16'd0,     1'b0, 17'd0,     1'b0},
    '{16'd10,    1'b0, 17'd0,     1'b0},
    '{16'd65535, 1'b0, 17'd0,     1'b0},
    '{16'd100,   1'b0, 17'd0,     1'b0},
    // Three invalid samples push the median into the invalid range.
    '{16'd0,     1'b0, 17'd0,     1'b0},
    '{16'd5,     1'b0, 17'd0,     1'b0},
    '{16'd0,     1'b0, 17'd0,     1'b0},
    '{16'd7,     1'b0, 17'd0,     1'b0},
    '{16'd40000, 1'b0, 17'd0,     1'b0}
  };

  echo_range_median5_filter #(
    .WINDOW(WINDOW)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .echo_us          (echo_us),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .distance_centi_cm(distance_centi_cm),
    .distance_valid   (distance_valid)
  );

  // Clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("echo_range_median5_filter_test: errors");
      $finish;
    end
  end

  // Stored sample word: invalid mark over a zero distance, or the distance
  // floor(echo * 17 / 10) with the mark clear.
  function automatic logic [SAMPLE_W-1:0] echo_to_sample(input logic [ECHO_W-1:0] echo);
    logic [31:0] scaled;
    scaled = (32'(echo) * 32'd17) / 32'd10;
    if (echo == '0 || echo > limit_us)
      return {1'b1, {DIST_W{1'b0}}};
    return {1'b0, scaled[DIST_W-1:0]};
  endfunction

  // Add one echo to the group; when the group fills, sort it on the whole
  // sample word and return the middle entry.
  task automatic predict_median(input logic [ECHO_W-1:0] echo, output bit closes,
                                output median_t median);
    logic [SAMPLE_W-1:0] ordered [WINDOW];
    logic [SAMPLE_W-1:0] swap;
    logic [SAMPLE_W-1:0] middle;
    group_samples[group_fill] = echo_to_sample(echo);
    group_fill++;
    closes = 1'b0;
    median = '0;
    if (group_fill == WINDOW) begin
      group_fill = 0;
      closes = 1'b1;
      for (int i = 0; i < WINDOW; i++)
        ordered[i] = group_samples[i];
      for (int i = 0; i < WINDOW - 1; i++)
        for (int j = 0; j < WINDOW - 1 - i; j++)
          if (ordered[j] > ordered[j+1]) begin
            swap         = ordered[j];
            ordered[j]   = ordered[j+1];
            ordered[j+1] = swap;
          end
      middle = ordered[WINDOW/2];
      if (!middle[SAMPLE_W-1])
        median = '{distance: middle[DIST_W-1:0], valid: 1'b1};
    end
  endtask

  // Present one beat after a gap of idle cycles and wait until it is taken.
  // The call starts and ends in the time step of a rising edge.
  task automatic send_echo(input logic [ECHO_W-1:0] echo, input int gap, output bit closes,
                           output median_t median);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    echo_us <= echo;
    do @(posedge clk); while (busy);
    predict_median(echo, closes, median);
  endtask

  // Write the timeout register once the block has drained.
  task automatic write_timeout(input logic [ECHO_W-1:0] value);
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_us  = value;
  endtask

  // Echo draw: corner values, the full range, and a band around the timeout.
  function automatic logic [ECHO_W-1:0] draw_echo();
    int band;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 16'd1;
          2: return limit_us;
          3: return limit_us + 16'd1;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return ECHO_W'($urandom);
      default: begin
        band = int'(limit_us) + int'(limit_us) / 4 + 1;
        if (band > 65535)
          band = 65535;
        return ECHO_W'($urandom_range(0, band));
      end
    endcase
  endfunction

  // Compare each done beat with the oldest predicted median.
  always @(posedge clk) begin
    median_t want;
    if (!rst && done) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result: distance_centi_cm %0d, distance_valid %0d",
               distance_centi_cm, distance_valid);
        mismatch_count++;
      end else begin
        want = pending_medians.pop_front();
        if (distance_centi_cm !== want.distance) begin
          $error("distance_centi_cm: expected %0d, got %0d", want.distance,
                 distance_centi_cm);
          mismatch_count++;
        end
        if (distance_valid !== want.valid) begin
          $error("distance_valid: expected %0d, got %0d", want.valid, distance_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    bit                closes;
    median_t           median;
    bit                no_idle;
    int                gap;
    logic [ECHO_W-1:0] setting;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset timeout.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_echo(directed_rows[r].echo, $urandom_range(0, 9), closes, median);
      if (closes) begin
        if (directed_rows[r].typed)
          median = '{distance: directed_rows[r].distance, valid: directed_rows[r].valid};
        pending_medians.push_back(median);
      end
    end
    start <= 1'b0;

    // Random phases, each under its own timeout setting.
    no_idle = 1'b0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: setting = 16'hFFFF;
        1: setting = '0;
        2: setting = 16'd1;
        default: setting = ECHO_W'($urandom_range(1, 65535));
      endcase
      write_timeout(setting);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Stretches of back-to-back beats among randomly idled ones.
        if (n % 30 == 0)
          no_idle = ($urandom_range(0, 3) == 0);
        gap = no_idle ? 0 : $urandom_range(0, 9);
        send_echo(draw_echo(), gap, closes, median);
        if (closes)
          pending_medians.push_back(median);
      end
      start <= 1'b0;
    end

    // Drain and let the block settle before the verdict.
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("echo_range_median5_filter_test: clean");
    else
      $display("echo_range_median5_filter_test: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/erm5_pkg.sv
rtl/erm5_ctrl.sv
rtl/erm5_datapath.sv
rtl/echo_range_median5_filter.sv
test/echo_range_median5_filter_test.sv
